// ===== src/lzss_win_pkg.sv =====
`default_nettype none
package lzss_win_pkg;

	// window geometry and token layout
	localparam int WINDOW_BYTES = 8192;
	localparam int WIN_AW       = 13;
	localparam int LEN_W        = 4;
	localparam int MIN_MATCH    = 3;
	localparam int CTRL_BITS    = 8;
	localparam int BITS_W       = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_word_t;

	typedef enum logic [1:0] {
		PH_CONTROL = 2'd0,
		PH_ITEM    = 2'd1,
		PH_HIGH    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OP_LITERAL = 2'd0,
		OP_COPY    = 2'd1,
		OP_RESTART = 2'd2
	} op_kind_t;

	// one queued command: literal byte in arg[7:0], or copy source + length
	typedef struct packed {
		op_kind_t            kind;
		logic [WIN_AW-1:0]   arg;
		logic [LEN_W-1:0]    len;
	} op_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic not_empty;
		op_t  head;
	} q_out_t;

endpackage
`default_nettype wire

// ===== src/lzss_window_decompressor.sv =====
`default_nettype none
// LZSS decompressor with an 8 KiB ring window. Compressed bytes enter on the
// comp channel, one word per byte, with stream_start set on the first byte of
// each stream; decompressed bytes leave on the data channel in order, and
// last_of_run marks the final byte produced by one input byte. A flag byte
// supplies eight control bits, LSB first: 1 = literal byte, 0 = two-byte
// little-endian token (top 3 bits + 3 = length 3..10, low 13 bits = absolute
// window position). Copies may overlap bytes they have just written.
// Timing: the front parser takes one input word per cycle while the command
// queue has room. The back end writes one window byte per cycle through the
// single RAM write port: a literal writes one byte, a token 3 to 10 bytes, and
// flag bytes and token low bytes queue no command for it. A stream start
// needs no clearing pass: entries at or above the write pointer read as zero
// until the pointer first wraps. The data channel keeps one output register;
// the back end halts only while a finished byte sits in it with data_stall
// high.
module lzss_window_decompressor
	import lzss_win_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      comp_valid,
	output logic           comp_stall,
	input  wire in_word_t  comp_word,
	output logic           data_valid,
	input  wire logic      data_stall,
	output out_word_t      data_word
);

	logic   q_full;
	logic   push;
	op_t    push_op;
	logic   pop;
	q_out_t q_out;

	// flag/token parser
	lzss_win_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp_valid (comp_valid),
		.comp_word  (comp_word),
		.comp_stall (comp_stall),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	// decouples parsing from the copy engine
	lzss_win_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.q_out   (q_out)
	);

	// window RAM, copy sequencer and output register
	lzss_win_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_out      (q_out),
		.pop        (pop),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_word  (data_word)
	);

	// no command may be pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("command pushed into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_out.not_empty)
		else $error("command popped from empty queue");

	// an accepted stream start always queues a restart
	a_restart_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(comp_valid && !comp_stall && comp_word.stream_start)
		|-> (push && push_op.kind == OP_RESTART))
		else $error("stream start did not queue a restart");

endmodule
`default_nettype wire

// ===== src/lzss_win_ram.sv =====
`default_nettype none
module lzss_win_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first; rdata holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/lzss_win_front.sv =====
`default_nettype none
module lzss_win_front
	import lzss_win_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     comp_valid,
	input  wire in_word_t comp_word,
	output logic          comp_stall,
	input  wire logic     q_full,
	output logic          push,
	output op_t           push_op
);

	phase_t              phase_q, phase_d, phase_e;
	logic [7:0]          ctrl_q, ctrl_d, ctrl_e;
	logic [BITS_W-1:0]   bits_q, bits_d, bits_e;
	logic [7:0]          tok_q, tok_d;
	logic                fire;
	logic [7:0]          b;

	assign comp_stall = q_full;
	assign fire       = comp_valid && !q_full;
	assign b          = comp_word.in_byte;

	// stream start puts the parser back at its reset state before this byte
	always_comb begin
		phase_e = comp_word.stream_start ? PH_CONTROL : phase_q;
		ctrl_e  = comp_word.stream_start ? 8'h00 : ctrl_q;
		bits_e  = comp_word.stream_start ? '0 : bits_q;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		ctrl_d  = ctrl_q;
		bits_d  = bits_q;
		tok_d   = tok_q;
		if (fire) begin
			if (comp_word.stream_start) begin
				tok_d = 8'h00;
			end
			case (phase_e)
				PH_ITEM: begin
					if (bits_e == '0) begin
						ctrl_d  = b;
						bits_d  = BITS_W'(CTRL_BITS);
						phase_d = PH_ITEM;
					end else if (ctrl_e[0]) begin
						ctrl_d  = ctrl_e >> 1;
						bits_d  = bits_e - 1'b1;
						phase_d = (bits_e == BITS_W'(1)) ? PH_CONTROL : PH_ITEM;
					end else begin
						tok_d   = b;
						phase_d = PH_HIGH;
					end
				end
				PH_HIGH: begin
					ctrl_d  = ctrl_e >> 1;
					bits_d  = bits_e - 1'b1;
					phase_d = (bits_e == BITS_W'(1)) ? PH_CONTROL : PH_ITEM;
				end
				default: begin
					ctrl_d  = b;
					bits_d  = BITS_W'(CTRL_BITS);
					phase_d = PH_ITEM;
				end
			endcase
		end
	end

	// outputs: at most one command per accepted byte
	always_comb begin
		push         = 1'b0;
		push_op.kind = OP_LITERAL;
		push_op.arg  = {{(WIN_AW-8){1'b0}}, b};
		push_op.len  = '0;
		if (fire) begin
			if (comp_word.stream_start) begin
				push         = 1'b1;
				push_op.kind = OP_RESTART;
			end else if (phase_e == PH_HIGH) begin
				push         = 1'b1;
				push_op.kind = OP_COPY;
				push_op.arg  = {b[WIN_AW-9:0], tok_q};
				push_op.len  = {1'b0, b[7:WIN_AW-8]} + LEN_W'(MIN_MATCH);
			end else if (phase_e == PH_ITEM && bits_e != '0 && ctrl_e[0]) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CONTROL;
			ctrl_q  <= 8'h00;
			bits_q  <= '0;
			tok_q   <= 8'h00;
		end else begin
			phase_q <= phase_d;
			ctrl_q  <= ctrl_d;
			bits_q  <= bits_d;
			tok_q   <= tok_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/lzss_win_queue.sv =====
`default_nettype none
module lzss_win_queue
	import lzss_win_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output q_out_t    q_out
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full            = (count_q == CW'(DEPTH));
	assign q_out.not_empty = (count_q != '0);
	assign q_out.head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/lzss_win_back.sv =====
`default_nettype none
module lzss_win_back
	import lzss_win_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire q_out_t q_out,
	output logic        pop,
	output logic        data_valid,
	input  wire logic   data_stall,
	output out_word_t   data_word
);

	// copy sequencer
	logic              busy_q;
	logic [WIN_AW-1:0] cpos_q;
	logic [LEN_W-1:0]  crem_q;

	// read stage
	logic              valid_s1;
	op_kind_t          kind_s1;
	logic [WIN_AW-1:0] arg_s1;
	logic              last_s1;

	// same-address bypass around the read-first RAM
	logic              fwd_hit_q;
	logic [7:0]        fwd_data_q;

	// window write side; entries below wp_q (or all, once wrapped) are valid
	logic [WIN_AW-1:0] wp_q;
	logic              wrapped_q;

	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              out_free, move_s1, load_s1, issue_cont, re, we, written;
	logic [WIN_AW-1:0] ra;
	logic [7:0]        rdata, rd_byte, wr_byte;

	always_comb begin
		out_free   = !out_valid_q || !data_stall;
		move_s1    = valid_s1 && (kind_s1 == OP_RESTART || out_free);
		load_s1    = !valid_s1 || move_s1;
		we         = move_s1 && kind_s1 != OP_RESTART;
		issue_cont = load_s1 && busy_q;
		pop        = load_s1 && !busy_q && q_out.not_empty;
		re         = issue_cont || (pop && q_out.head.kind == OP_COPY);
		ra         = busy_q ? cpos_q : q_out.head.arg;
		written    = wrapped_q || (arg_s1 < wp_q);
		rd_byte    = fwd_hit_q ? fwd_data_q : rdata;
		if (kind_s1 == OP_LITERAL) begin
			wr_byte = arg_s1[7:0];
		end else begin
			wr_byte = written ? rd_byte : 8'h00;
		end
	end

	lzss_win_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (wr_byte),
		.re    (re),
		.raddr (ra),
		.rdata (rdata)
	);

	// payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1 <= busy_q ? OP_COPY : q_out.head.kind;
			arg_s1  <= ra;
			last_s1 <= busy_q ? (crem_q == LEN_W'(1)) : (q_out.head.kind != OP_COPY);
		end
		if (issue_cont) begin
			cpos_q <= cpos_q + 1'b1;
			crem_q <= crem_q - 1'b1;
		end else if (pop) begin
			cpos_q <= q_out.head.arg + 1'b1;
			crem_q <= q_out.head.len - 1'b1;
		end
		if (re) begin
			fwd_data_q <= wr_byte;
		end
		if (out_free && we) begin
			out_word_q.out_byte    <= wr_byte;
			out_word_q.last_of_run <= last_s1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			fwd_hit_q   <= 1'b0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_cont) begin
				busy_q <= (crem_q != LEN_W'(1));
			end else if (pop && q_out.head.kind == OP_COPY) begin
				busy_q <= 1'b1;
			end
			if (load_s1) begin
				valid_s1 <= issue_cont || pop;
			end
			if (re) begin
				fwd_hit_q <= we && (wp_q == ra);
			end
			if (move_s1) begin
				if (kind_s1 == OP_RESTART) begin
					wp_q      <= '0;
					wrapped_q <= 1'b0;
				end else begin
					wp_q <= wp_q + 1'b1;
					if (wp_q == '1) begin
						wrapped_q <= 1'b1;
					end
				end
			end
			if (out_free) begin
				out_valid_q <= we;
			end
		end
	end

	assign data_valid = out_valid_q;
	assign data_word  = out_word_q;

endmodule
`default_nettype wire
